>>> rtl/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define PGSE_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked on every edge, reset included
`define PGSE_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/pgse_pkg.sv
// types, constants and byte tables of the grayscale png stored-deflate encoder
`default_nettype none
package pgse_pkg;

    localparam logic [12:0] MAX_WIDTH   = 13'd4096;
    localparam logic [12:0] MAX_HEIGHT  = 13'd4096;
    localparam logic [31:0] BLOCK_LIMIT = 32'd65535;
    localparam logic [16:0] ADLER_MOD   = 17'd65521;
    localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
    localparam logic [31:0] ALL_ONES    = 32'hFFFFFFFF;

    // sequence positions
    localparam logic [5:0] START_LAST = 6'd42;
    localparam logic [5:0] FIN_LAST   = 6'd19;
    localparam logic [5:0] HDR_LAST   = 6'd4;

    // input commands
    localparam logic [1:0] CMD_MEASURE = 2'd0;
    localparam logic [1:0] CMD_START   = 2'd1;
    localparam logic [1:0] CMD_ENCODE  = 2'd2;

    // register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SCALE  = 2'd2;

    typedef enum logic [2:0] {
        BS_CONST, BS_W, BS_H, BS_CRC, BS_LEN, BS_ADLER, BS_HDR, BS_PIX
    } t_bsel;

    typedef struct packed {
        t_bsel      sel;
        logic [2:0] k;
        logic [7:0] cval;
        logic       crc_en;
        logic       crc_init;
    } t_seq_ent;

    // controller to datapath
    typedef struct packed {
        logic     emit;
        t_seq_ent ent;
        logic     last;
        logic     eof;
        logic     data_en;
        logic     hdr_last;
        logic     pix_en;
        logic     fin_clear;
        logic     start_img;
        logic     measure;
        logic     div_go;
        logic     div_blocks;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic div_busy;
        logic active;
        logic blk_empty;
        logic col_zero;
        logic img_last;
    } t_stat;

    function automatic logic [31:0] crc_byte(input logic [31:0] seed, input logic [7:0] b);
        logic [31:0] c;
        c = seed ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // byte k of a word, k zero is the most significant
    function automatic logic [7:0] byte_of(input logic [31:0] w, input logic [1:0] k);
        logic [7:0] b;
        unique case (k)
            2'd0: b = w[31:24];
            2'd1: b = w[23:16];
            2'd2: b = w[15:8];
            default: b = w[7:0];
        endcase
        return b;
    endfunction

    function automatic t_seq_ent mk(input t_bsel s, input logic [2:0] k, input logic [7:0] v,
                                    input logic ce, input logic ci);
        t_seq_ent e;
        e.sel = s; e.k = k; e.cval = v; e.crc_en = ce; e.crc_init = ci;
        return e;
    endfunction

    // signature, ihdr, idat length and type, zlib header
    function automatic t_seq_ent start_entry(input logic [5:0] idx);
        t_seq_ent e;
        e = mk(BS_CONST, 3'd0, 8'h00, 1'b0, 1'b0);
        unique case (idx)
            6'd0:  e = mk(BS_CONST, 3'd0, 8'h89, 1'b0, 1'b0);
            6'd1:  e = mk(BS_CONST, 3'd0, 8'h50, 1'b0, 1'b0);
            6'd2:  e = mk(BS_CONST, 3'd0, 8'h4E, 1'b0, 1'b0);
            6'd3:  e = mk(BS_CONST, 3'd0, 8'h47, 1'b0, 1'b0);
            6'd4:  e = mk(BS_CONST, 3'd0, 8'h0D, 1'b0, 1'b0);
            6'd5:  e = mk(BS_CONST, 3'd0, 8'h0A, 1'b0, 1'b0);
            6'd6:  e = mk(BS_CONST, 3'd0, 8'h1A, 1'b0, 1'b0);
            6'd7:  e = mk(BS_CONST, 3'd0, 8'h0A, 1'b0, 1'b0);
            6'd11: e = mk(BS_CONST, 3'd0, 8'h0D, 1'b0, 1'b0);
            6'd12: e = mk(BS_CONST, 3'd0, 8'h49, 1'b1, 1'b1);
            6'd13: e = mk(BS_CONST, 3'd0, 8'h48, 1'b1, 1'b0);
            6'd14: e = mk(BS_CONST, 3'd0, 8'h44, 1'b1, 1'b0);
            6'd15: e = mk(BS_CONST, 3'd0, 8'h52, 1'b1, 1'b0);
            6'd16, 6'd17, 6'd18, 6'd19:
                e = mk(BS_W, 3'(idx - 6'd16), 8'h00, 1'b1, 1'b0);
            6'd20, 6'd21, 6'd22, 6'd23:
                e = mk(BS_H, 3'(idx - 6'd20), 8'h00, 1'b1, 1'b0);
            6'd24: e = mk(BS_CONST, 3'd0, 8'h08, 1'b1, 1'b0);
            6'd25, 6'd26, 6'd27, 6'd28:
                e = mk(BS_CONST, 3'd0, 8'h00, 1'b1, 1'b0);
            6'd29, 6'd30, 6'd31, 6'd32:
                e = mk(BS_CRC, 3'(idx - 6'd29), 8'h00, 1'b0, 1'b0);
            6'd33, 6'd34, 6'd35, 6'd36:
                e = mk(BS_LEN, 3'(idx - 6'd33), 8'h00, 1'b0, 1'b0);
            6'd37: e = mk(BS_CONST, 3'd0, 8'h49, 1'b1, 1'b1);
            6'd38: e = mk(BS_CONST, 3'd0, 8'h44, 1'b1, 1'b0);
            6'd39: e = mk(BS_CONST, 3'd0, 8'h41, 1'b1, 1'b0);
            6'd40: e = mk(BS_CONST, 3'd0, 8'h54, 1'b1, 1'b0);
            6'd41: e = mk(BS_CONST, 3'd0, 8'h78, 1'b1, 1'b0);
            6'd42: e = mk(BS_CONST, 3'd0, 8'h01, 1'b1, 1'b0);
            default: e = mk(BS_CONST, 3'd0, 8'h00, 1'b0, 1'b0);
        endcase
        return e;
    endfunction

    // adler, idat crc, iend chunk
    function automatic t_seq_ent fin_entry(input logic [5:0] idx);
        t_seq_ent e;
        e = mk(BS_CONST, 3'd0, 8'h00, 1'b0, 1'b0);
        unique case (idx)
            6'd0, 6'd1, 6'd2, 6'd3:
                e = mk(BS_ADLER, {1'b0, idx[1:0]}, 8'h00, 1'b1, 1'b0);
            6'd4, 6'd5, 6'd6, 6'd7, 6'd16, 6'd17, 6'd18, 6'd19:
                e = mk(BS_CRC, {1'b0, idx[1:0]}, 8'h00, 1'b0, 1'b0);
            6'd12: e = mk(BS_CONST, 3'd0, 8'h49, 1'b1, 1'b1);
            6'd13: e = mk(BS_CONST, 3'd0, 8'h45, 1'b1, 1'b0);
            6'd14: e = mk(BS_CONST, 3'd0, 8'h4E, 1'b1, 1'b0);
            6'd15: e = mk(BS_CONST, 3'd0, 8'h44, 1'b1, 1'b0);
            default: e = mk(BS_CONST, 3'd0, 8'h00, 1'b0, 1'b0);
        endcase
        return e;
    endfunction

endpackage
`default_nettype wire

>>> rtl/pgse_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module pgse_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_go,
    input  wire logic [39:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_busy,
    output logic [39:0]      o_quot
);
    localparam int NUM_W = 40;

    logic              r_busy;
    logic [5:0]        r_cnt;
    logic [NUM_W-1:0]  r_num;
    logic [31:0]       r_rem;
    logic [31:0]       r_den;
    logic [32:0]       w_trial;
    logic              w_fits;

    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_fits  = w_trial >= {1'b0, r_den};

    // shift numerator out, quotient bits in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'(NUM_W - 1);
            r_num  <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem  <= w_fits ? 32'(w_trial - {1'b0, r_den}) : w_trial[31:0];
            r_num  <= {r_num[NUM_W-2:0], w_fits};
            r_cnt  <= r_cnt - 6'd1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_num;
endmodule
`default_nettype wire

>>> rtl/pgse_ctrl.sv
// sequencing state machine of the png encoder
`default_nettype none
module pgse_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic [1:0]    i_command,
    output logic               o_in_stall,
    input  wire pgse_pkg::t_stat i_stat,
    output pgse_pkg::t_cmd     o_cmd
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_TOTAL, ST_START, ST_DIVW, ST_RAW, ST_HDR, ST_FIN
    } t_state;

    t_state      r_state, n_state;
    logic [5:0]  r_idx, n_idx;
    logic        r_phase, n_phase;
    logic        w_accept;

    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_phase = r_phase;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_command)
                        pgse_pkg::CMD_MEASURE: o_cmd.measure = !i_stat.active;
                        pgse_pkg::CMD_START: begin
                            o_cmd.start_img = 1'b1;
                            n_state = ST_TOTAL;
                        end
                        pgse_pkg::CMD_ENCODE: begin
                            if (i_stat.active) begin
                                o_cmd.div_go = 1'b1;
                                n_state = ST_DIVW;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_TOTAL: begin
                o_cmd.div_blocks = 1'b1;
                n_idx   = '0;
                n_state = ST_START;
            end
            ST_START: begin
                o_cmd.ent = pgse_pkg::start_entry(r_idx);
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (r_idx == pgse_pkg::START_LAST) begin
                        o_cmd.last = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + 6'd1;
                    end
                end
            end
            ST_DIVW: begin
                if (!i_stat.div_busy) begin
                    n_phase = !i_stat.col_zero;
                    n_state = ST_RAW;
                end
            end
            ST_RAW: begin
                o_cmd.ent = pgse_pkg::mk(r_phase ? pgse_pkg::BS_PIX : pgse_pkg::BS_CONST,
                                         3'd0, 8'h00, 1'b1, 1'b0);
                if (i_stat.blk_empty) begin
                    n_idx   = '0;
                    n_state = ST_HDR;
                end else if (i_stat.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.data_en = 1'b1;
                    if (!r_phase) begin
                        n_phase = 1'b1;
                    end else begin
                        o_cmd.pix_en = 1'b1;
                        n_idx = '0;
                        if (i_stat.img_last) begin
                            n_state = ST_FIN;
                        end else begin
                            o_cmd.last = 1'b1;
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            ST_HDR: begin
                o_cmd.ent = pgse_pkg::mk(pgse_pkg::BS_HDR, r_idx[2:0], 8'h00, 1'b1, 1'b0);
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (r_idx == pgse_pkg::HDR_LAST) begin
                        o_cmd.hdr_last = 1'b1;
                        n_state = ST_RAW;
                    end else begin
                        n_idx = r_idx + 6'd1;
                    end
                end
            end
            ST_FIN: begin
                o_cmd.ent = pgse_pkg::fin_entry(r_idx);
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (r_idx == pgse_pkg::FIN_LAST) begin
                        o_cmd.last      = 1'b1;
                        o_cmd.eof       = 1'b1;
                        o_cmd.fin_clear = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + 6'd1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_phase <= n_phase;
        end
    end
endmodule
`default_nettype wire

>>> rtl/pgse_dp.sv
// datapath: registers, checksums, byte select, output register
`default_nettype none
module pgse_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [31:0]   i_pixel_value,
    input  wire pgse_pkg::t_cmd i_cmd,
    output pgse_pkg::t_stat    o_stat,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    input  wire logic          i_out_stall,
    output logic               o_out_valid,
    output logic [7:0]         o_out_byte,
    output logic               o_last_of_run,
    output logic               o_end_of_file
);
    logic [12:0] r_width, r_height, r_lat_w, r_lat_h;
    logic [31:0] r_scale, r_rmax, r_lat_max, r_crc;
    logic [24:0] r_total, r_pos;
    logic [8:0]  r_blocks;
    logic [11:0] r_col, r_row;
    logic [15:0] r_blk, r_alo, r_ahi;
    logic        r_active;
    logic        r_out_valid, r_last, r_eof;
    logic [7:0]  r_out_byte;

    logic [26:0] w_prod;
    logic [39:0] w_num, w_quot;
    logic [31:0] w_den, w_idat_len, w_crc_seed;
    logic        w_div_busy, w_out_free, w_wr;
    logic [24:0] w_bnum;
    logic [8:0]  w_bq0, w_blocks;
    logic [16:0] w_brem;
    logic [24:0] w_rem;
    logic        w_final;
    logic [15:0] w_len, w_alo_n, w_ahi_n;
    logic [16:0] w_lo_sum, w_hi_sum;
    logic [7:0]  w_pix, w_hdr, w_byte;

    function automatic logic [12:0] clamp_dim(input logic [12:0] v, input logic [12:0] lim);
        logic [12:0] r;
        r = (v == '0) ? 13'd1 : ((v > lim) ? lim : v);
        return r;
    endfunction

    // total filtered bytes and divider operands
    assign w_prod = 27'(r_lat_h) * 27'({1'b0, r_lat_w} + 14'd1);
    assign w_num  = {i_pixel_value, 8'd0} - 40'(i_pixel_value);
    assign w_den  = r_lat_max;

    // stored block count, ceil(total / 65535) by a shift and one correction
    assign w_bnum   = w_prod[24:0] + 25'(pgse_pkg::BLOCK_LIMIT - 32'd1);
    assign w_bq0    = w_bnum[24:16];
    assign w_brem   = 17'(w_bnum[15:0]) + 17'(w_bq0);
    assign w_blocks = w_bq0 + 9'(w_brem >= 17'(pgse_pkg::BLOCK_LIMIT));

    pgse_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.div_go),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    assign w_idat_len = (32'(r_blocks) << 2) + 32'(r_blocks) + 32'(r_total) + 32'd6;
    assign w_pix = (r_lat_max == '0) ? 8'd0 : ((|w_quot[39:8]) ? 8'd255 : w_quot[7:0]);

    // stored block header
    assign w_rem   = r_total - r_pos;
    assign w_final = (w_rem[24:16] == '0);
    assign w_len   = w_final ? w_rem[15:0] : 16'hFFFF;
    always_comb begin
        unique case (i_cmd.ent.k)
            3'd0: w_hdr = {7'd0, w_final};
            3'd1: w_hdr = w_len[7:0];
            3'd2: w_hdr = w_len[15:8];
            3'd3: w_hdr = ~w_len[7:0];
            default: w_hdr = ~w_len[15:8];
        endcase
    end

    // byte select
    always_comb begin
        unique case (i_cmd.ent.sel)
            pgse_pkg::BS_W:     w_byte = pgse_pkg::byte_of(32'(r_lat_w), i_cmd.ent.k[1:0]);
            pgse_pkg::BS_H:     w_byte = pgse_pkg::byte_of(32'(r_lat_h), i_cmd.ent.k[1:0]);
            pgse_pkg::BS_CRC:   w_byte = pgse_pkg::byte_of(~r_crc, i_cmd.ent.k[1:0]);
            pgse_pkg::BS_LEN:   w_byte = pgse_pkg::byte_of(w_idat_len, i_cmd.ent.k[1:0]);
            pgse_pkg::BS_ADLER: w_byte = pgse_pkg::byte_of({r_ahi, r_alo}, i_cmd.ent.k[1:0]);
            pgse_pkg::BS_HDR:   w_byte = w_hdr;
            pgse_pkg::BS_PIX:   w_byte = w_pix;
            default:            w_byte = i_cmd.ent.cval;
        endcase
    end

    // adler-32 step
    assign w_lo_sum = 17'(r_alo) + 17'(w_byte);
    assign w_alo_n  = (w_lo_sum >= pgse_pkg::ADLER_MOD) ? 16'(w_lo_sum - pgse_pkg::ADLER_MOD)
                                                         : w_lo_sum[15:0];
    assign w_hi_sum = 17'(r_ahi) + 17'(w_alo_n);
    assign w_ahi_n  = (w_hi_sum >= pgse_pkg::ADLER_MOD) ? 16'(w_hi_sum - pgse_pkg::ADLER_MOD)
                                                         : w_hi_sum[15:0];

    assign w_crc_seed = i_cmd.ent.crc_init ? pgse_pkg::ALL_ONES : r_crc;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_wr       = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 13'd1;
            r_height <= 13'd1;
            r_scale  <= '0;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                pgse_pkg::REG_WIDTH:  r_width  <= pwdata[12:0];
                pgse_pkg::REG_HEIGHT: r_height <= pwdata[12:0];
                pgse_pkg::REG_SCALE:  r_scale  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            pgse_pkg::REG_WIDTH:  prdata = 32'(r_width);
            pgse_pkg::REG_HEIGHT: prdata = 32'(r_height);
            pgse_pkg::REG_SCALE:  prdata = r_scale;
            default:              prdata = '0;
        endcase
    end

    // image state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_rmax    <= '0;
            r_lat_w   <= 13'd1;
            r_lat_h   <= 13'd1;
            r_lat_max <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_pos     <= '0;
            r_blk     <= '0;
            r_alo     <= 16'd1;
            r_ahi     <= '0;
            r_crc     <= pgse_pkg::ALL_ONES;
        end else begin
            if (i_cmd.measure && (i_pixel_value > r_rmax)) begin
                r_rmax <= i_pixel_value;
            end
            if (i_cmd.start_img) begin
                r_lat_w   <= clamp_dim(r_width, pgse_pkg::MAX_WIDTH);
                r_lat_h   <= clamp_dim(r_height, pgse_pkg::MAX_HEIGHT);
                r_lat_max <= (r_scale != '0) ? r_scale : r_rmax;
                r_col     <= '0;
                r_row     <= '0;
                r_pos     <= '0;
                r_blk     <= '0;
                r_alo     <= 16'd1;
                r_ahi     <= '0;
                r_active  <= 1'b1;
            end
            if (i_cmd.div_blocks) begin
                r_total  <= w_prod[24:0];
                r_blocks <= w_blocks;
            end
            if (i_cmd.emit && i_cmd.ent.crc_en) begin
                r_crc <= pgse_pkg::crc_byte(w_crc_seed, w_byte);
            end
            if (i_cmd.hdr_last) begin
                r_blk <= w_len;
            end
            if (i_cmd.data_en) begin
                r_alo <= w_alo_n;
                r_ahi <= w_ahi_n;
                r_pos <= r_pos + 25'd1;
                r_blk <= r_blk - 16'd1;
            end
            if (i_cmd.pix_en) begin
                if (13'(r_col) + 13'd1 == r_lat_w) begin
                    r_col <= '0;
                    r_row <= r_row + 12'd1;
                end else begin
                    r_col <= r_col + 12'd1;
                end
            end
            if (i_cmd.fin_clear) begin
                r_active <= 1'b0;
                r_rmax   <= '0;
                r_col    <= '0;
                r_row    <= '0;
                r_pos    <= '0;
                r_blk    <= '0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
            r_out_byte  <= w_byte;
            r_last      <= i_cmd.last;
            r_eof       <= i_cmd.eof;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_last;
    assign o_end_of_file = r_eof;

    assign o_stat.out_free  = w_out_free;
    assign o_stat.div_busy  = w_div_busy;
    assign o_stat.active    = r_active;
    assign o_stat.blk_empty = (r_blk == '0);
    assign o_stat.col_zero  = (r_col == '0);
    assign o_stat.img_last  = (13'(r_col) + 13'd1 == r_lat_w) &&
                              (13'(r_row) + 13'd1 == r_lat_h);
endmodule
`default_nettype wire

>>> rtl/png_gray_stored_deflate_encoder.sv
// top level of the grayscale png encoder with stored deflate payload
//
//   channel   handshake               payload
//   input     i_in_valid/o_in_stall   i_command, i_pixel_value
//   output    o_out_valid/i_out_stall o_out_byte, o_last_of_run, o_end_of_file
//   config    psel/penable/pwrite     paddr, pwdata, prdata, pready
//
// measure: no output bytes. start: 43 bytes, one byte per cycle unless stalled.
// encode: the 40-step divider, then 1 to 27 bytes, one per cycle unless stalled.
// one input transfer at a time; the input stalls until its last byte is registered.
// a stalled output holds the byte and pauses the sequencer.
// reset is synchronous, active low, and needs no clearing pass.
`default_nettype none
module png_gray_stored_deflate_encoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic [31:0] i_pixel_value,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_last_of_run,
    output logic             o_end_of_file,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    pgse_pkg::t_cmd  w_cmd;
    pgse_pkg::t_stat w_stat;

    assign pready = 1'b1;

    pgse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    pgse_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pixel_value (i_pixel_value),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_end_of_file (o_end_of_file)
    );
endmodule
`default_nettype wire

>>> rtl/pgse_chk.sv
// port-level checker for the png encoder, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module pgse_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_last_of_run,
    input wire logic       o_end_of_file
);
    // end of file closes the run of its input
    `PGSE_ASSERT(a_eof_last, i_clk, i_rst_n, o_out_valid && o_end_of_file |-> o_last_of_run, "eof without last")
    // a stalled byte holds
    `PGSE_ASSERT(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte), "stalled byte changed")
    // nothing valid right after reset
    `PGSE_ASSERT_ALWAYS(a_rst, i_clk, !i_rst_n |=> !o_out_valid, "valid after reset")
endmodule

bind png_gray_stored_deflate_encoder pgse_chk u_chk (.*);
`default_nettype wire

>>> tb/sv/tb.sv
// testbench for the grayscale png stored-deflate encoder: byte stream predicted and checked
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       eof;
    } t_png_byte;

    // png stream predictor and store of expected bytes
    class png_scoreboard;
        int unsigned reg_w = 1, reg_h = 1, reg_scale = 0;
        int unsigned peak, col, row, lat_w = 1, lat_h = 1, lat_max;
        longint unsigned pos;
        int unsigned blk_left, ad_lo = 1, ad_hi, crc = 32'hFFFFFFFF;
        bit active;
        t_png_byte pending[$];
        t_png_byte run[$];
        int errors;

        // one line per mismatch, counted
        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function void emit(logic [7:0] b);
            t_png_byte e;
            e.data = b; e.last = 0; e.eof = 0;
            run.insert(run.size(), e);
        endfunction

        function void emit_crc(logic [7:0] b);
            logic [31:0] c;
            c = crc ^ {24'd0, b};
            for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
            crc = c;
            emit(b);
        endfunction

        function void emit_word(logic [31:0] v, bit with_crc);
            for (int s = 24; s >= 0; s -= 8)
                if (with_crc) emit_crc(v[s+:8]); else emit(v[s+:8]);
        endfunction

        function void emit_tag(logic [31:0] t);
            crc = 32'hFFFFFFFF;
            emit_word(t, 1);
        endfunction

        function void stored_byte(logic [7:0] b);
            longint unsigned rem;
            int unsigned len, nlen;
            if (blk_left == 0) begin
                rem = longint'(lat_h) * (lat_w + 1) - pos;
                len = rem < 65535 ? int'(rem) : 65535;
                nlen = ~len & 16'hFFFF;
                emit_crc(rem == len);
                emit_crc(len[7:0]); emit_crc(len[15:8]);
                emit_crc(nlen[7:0]); emit_crc(nlen[15:8]);
                blk_left = len;
            end
            emit_crc(b);
            ad_lo += b; if (ad_lo >= 65521) ad_lo -= 65521;
            ad_hi += ad_lo; if (ad_hi >= 65521) ad_hi -= 65521;
            pos++; blk_left--;
        endfunction

        function int unsigned clampd(int unsigned v);
            if (v == 0) return 1;
            return v > 4096 ? 4096 : v;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] v);
            if (idx == pgse_pkg::REG_WIDTH) reg_w = v[12:0];
            else if (idx == pgse_pkg::REG_HEIGHT) reg_h = v[12:0];
            else if (idx == pgse_pkg::REG_SCALE) reg_scale = v;
        endfunction

        // an accepted input transfer: predict its bytes
        function void note_input(logic [1:0] cmd, logic [31:0] v);
            longint unsigned total, blocks;
            longint unsigned s;
            logic [7:0] pix;
            run.delete();
            if (cmd == pgse_pkg::CMD_MEASURE) begin
                if (!active && v > peak) peak = v;
            end else if (cmd == pgse_pkg::CMD_START) begin
                lat_w = clampd(reg_w); lat_h = clampd(reg_h);
                lat_max = reg_scale != 0 ? reg_scale : peak;
                emit_word(32'h89504E47, 0); emit_word(32'h0D0A1A0A, 0);
                emit_word(13, 0); emit_tag(32'h49484452);
                emit_word(lat_w, 1); emit_word(lat_h, 1);
                emit_crc(8); emit_crc(0); emit_crc(0); emit_crc(0); emit_crc(0);
                emit_word(~crc, 0);
                total = longint'(lat_h) * (lat_w + 1);
                blocks = (total + 65534) / 65535;
                emit_word(32'(2 + 5 * blocks + total + 4), 0);
                emit_tag(32'h49444154);
                emit_crc(8'h78); emit_crc(8'h01);
                col = 0; row = 0; pos = 0; blk_left = 0; ad_lo = 1; ad_hi = 0;
                active = 1;
            end else if (cmd == pgse_pkg::CMD_ENCODE && active) begin
                pix = 0;
                if (lat_max != 0) begin
                    s = (longint'(v) * 255) / lat_max;
                    pix = s > 255 ? 8'd255 : s[7:0];
                end
                if (col == 0) stored_byte(0);
                stored_byte(pix);
                col++;
                if (col >= lat_w) begin
                    col = 0; row++;
                    if (row >= lat_h) begin
                        emit_word({ad_hi[15:0], ad_lo[15:0]}, 1);
                        emit_word(~crc, 0);
                        emit_word(0, 0);
                        emit_tag(32'h49454E44);
                        emit_word(~crc, 0);
                        run[$].eof = 1;
                        active = 0; peak = 0; col = 0; row = 0; pos = 0; blk_left = 0;
                    end
                end
            end
            if (run.size() > 0) run[$].last = 1;
            foreach (run[i]) pending.insert(pending.size(), run[i]);
        endfunction

        // an accepted output transfer
        task check_byte(logic [7:0] b, logic l, logic e);
            t_png_byte x;
            if (pending.size() == 0) begin
                report($sformatf("unexpected byte %h", b));
                return;
            end
            x = pending.pop_front();
            if (x.data !== b || x.last !== l || x.eof !== e)
                report($sformatf("got %h/%b/%b want %h/%b/%b", b, l, e, x.data, x.last, x.eof));
        endtask
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic i_in_valid = 0, i_out_stall = 0;
    logic [1:0] i_command = 0;
    logic [31:0] i_pixel_value = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [3:0] paddr = 0;
    logic [31:0] pwdata = 0;
    wire o_in_stall, o_out_valid, o_last_of_run, o_end_of_file, pready;
    wire [7:0] o_out_byte;
    wire [31:0] prdata;

    png_scoreboard sb = new();
    int send_idle = 16, recv_idle = 53;
    bit hold_recv, stim_done;
    int quiet;

    png_gray_stored_deflate_encoder dut (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    // output byte checking, and the watchdog on a quiet interface
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_byte(o_out_byte, o_last_of_run, o_end_of_file);
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 20000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver stall
    always @(negedge i_clk)
        i_out_stall <= hold_recv || ($urandom_range(99) < recv_idle);

    task automatic write_reg(logic [1:0] idx, logic [31:0] v);
        i_in_valid <= 0;
        psel <= 1; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
        @(negedge i_clk) penable <= 1;
        @(negedge i_clk) begin
            psel <= 0; penable <= 0; pwrite <= 0;
        end
        sb.write_reg(idx, v);
    endtask

    // send one input transfer; valid drops at the next idle cycle or other task
    task automatic send(logic [1:0] cmd, logic [31:0] v);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 0;
            @(negedge i_clk);
        end
        i_in_valid <= 1; i_command <= cmd; i_pixel_value <= v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(cmd, v);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_pix();
        case ($urandom_range(3))
            0: return 0;
            1: return 32'hFFFFFFFF;
            2: return $urandom_range(1000);
            default: return $urandom;
        endcase
    endfunction

    task automatic image(int w, int h, logic [31:0] sc, int measures);
        write_reg(pgse_pkg::REG_WIDTH, w); write_reg(pgse_pkg::REG_HEIGHT, h);
        write_reg(pgse_pkg::REG_SCALE, sc);
        repeat (measures) send(pgse_pkg::CMD_MEASURE, rand_pix());
        send(pgse_pkg::CMD_START, $urandom);
        for (int i = 0; i < w * h; i++) begin
            if ($urandom_range(19) == 0) send(pgse_pkg::CMD_MEASURE, $urandom);
            send(pgse_pkg::CMD_ENCODE, rand_pix());
        end
    endtask

    int n;
    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        // directed: ignored commands, zero maximum, full-scale pixel, odd registers
        send(pgse_pkg::CMD_ENCODE, 5);
        send(2'd3, 32'hFFFFFFFF);
        send(pgse_pkg::CMD_START, 0);
        send(pgse_pkg::CMD_ENCODE, 32'hFFFFFFFF);
        drain();
        write_reg(pgse_pkg::REG_WIDTH, 0); write_reg(pgse_pkg::REG_HEIGHT, 13'h1FFF);
        write_reg(pgse_pkg::REG_SCALE, 32'hFFFFFFFF);
        send(pgse_pkg::CMD_START, 0);
        send(pgse_pkg::CMD_ENCODE, 32'hFFFFFFFF);
        send(pgse_pkg::CMD_ENCODE, 0);
        drain();
        // abandon by start
        write_reg(pgse_pkg::REG_WIDTH, 2); write_reg(pgse_pkg::REG_HEIGHT, 2);
        write_reg(pgse_pkg::REG_SCALE, 100);
        send(pgse_pkg::CMD_START, 0);
        send(pgse_pkg::CMD_MEASURE, 32'hFFFFFFFF);
        send(pgse_pkg::CMD_ENCODE, 50); send(pgse_pkg::CMD_ENCODE, 200);
        send(pgse_pkg::CMD_ENCODE, 99);
        send(pgse_pkg::CMD_ENCODE, 100); drain();
        image(3, 1, 0, 3);
        drain();
        // long receiver hold while inputs keep coming
        hold_recv = 1;
        fork
            begin repeat (600) @(negedge i_clk); hold_recv = 0; end
            image(4, 2, 1, 0);
        join
        drain();
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin send_idle = 53; recv_idle = 16; end
            if (ph == 2) begin send_idle = 0; recv_idle = 0; end
            n = 0;
            while (n < 40) begin
                int w, h;
                w = $urandom_range(1, 6); h = $urandom_range(1, 4);
                image(w, h, ($urandom_range(1) ? 0 : $urandom), $urandom_range(3));
                n += w * h + 2;
                drain();
            end
        end
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
